/* hw/rtl/pstt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstt_pkg: shared types for the point step unit
// Transaction payloads, register indexes and controller/datapath signals.
// ----------------------------------------------------------------------------
package pstt_pkg;

    typedef struct packed {
        logic        cmd;
        logic [31:0] load_x;
        logic [31:0] load_y;
        logic [30:0] step_len;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic        arrived;
    } out_item_t;

    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_END_X   = 2'd2;
    localparam logic [1:0] REG_END_Y   = 2'd3;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic capture;
        logic prep;
        logic sqrt_start;
        logic sqrt_iter;
        logic div_start;
        logic div_iter;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic is_load;
        logic sqrt_last;
        logic div_last;
    } dp_stat_t;

endpackage

/* hw/rtl/pstt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstt_datapath: position, square root and division datapath
// Holds the position, a bit-serial integer square root, and two parallel
// restoring dividers that form the per-axis step velocity.
// ----------------------------------------------------------------------------
module pstt_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  pstt_pkg::dp_cmd_t  cmd,
    output pstt_pkg::dp_stat_t stat,
    input  pstt_pkg::in_item_t item,
    input  logic [31:0]        start_x,
    input  logic [31:0]        start_y,
    input  logic [31:0]        end_x,
    input  logic [31:0]        end_y,
    output logic [31:0]        pos_x,
    output logic [31:0]        pos_y
);
    import pstt_pkg::*;

    in_item_t    item_reg;
    logic [31:0] pos_x_reg;
    logic [31:0] pos_y_reg;
    logic        negx_reg;
    logic        negy_reg;
    logic [31:0] ax_reg;
    logic [31:0] ay_reg;
    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [5:0]  sq_cnt_reg;
    logic [31:0] len_reg;
    logic [62:0] dvx_reg;
    logic [62:0] dvy_reg;
    logic [63:0] remx_reg;
    logic [63:0] remy_reg;
    logic [62:0] qx_reg;
    logic [62:0] qy_reg;
    logic [5:0]  dv_cnt_reg;

    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] mx;
    logic [32:0] my;
    logic [32:0] hx;
    logic [32:0] hy;
    logic [63:0] trial;
    logic [63:0] rx_sh;
    logic [63:0] ry_sh;
    logic [63:0] vx;
    logic [63:0] vy;
    logic [31:0] newx;
    logic [31:0] newy;

    function automatic logic [31:0] move_axis(input logic [31:0] p, input logic [63:0] v,
                                              input logic [31:0] e);
        logic signed [63:0] s;
        logic signed [63:0] ps;
        logic signed [63:0] es;
        logic signed [63:0] r;
        begin
            ps = 64'(signed'(p));
            es = 64'(signed'(e));
            s  = ps + signed'(v);
            if (s > 64'sd2147483647)
            begin
                s = 64'sd2147483647;
            end
            else if (s < -64'sd2147483648)
            begin
                s = -64'sd2147483648;
            end
            r = ps;
            if (ps < es)
            begin
                r = (s > es) ? es : s;
            end
            else if (ps > es)
            begin
                r = (s < es) ? es : s;
            end
            move_axis = r[31:0];
        end
    endfunction

    assign dx = 33'(signed'(end_x)) - 33'(signed'(start_x));
    assign dy = 33'(signed'(end_y)) - 33'(signed'(start_y));
    assign mx = dx[32] ? -dx : dx;
    assign my = dy[32] ? -dy : dy;
    assign hx = (mx[32] || my[32] || mx[31] || my[31]) ? (mx >> 1) : mx;
    assign hy = (mx[32] || my[32] || mx[31] || my[31]) ? (my >> 1) : my;

    assign trial = res_reg + bit_reg;
    assign rx_sh = {remx_reg[62:0], dvx_reg[62]};
    assign ry_sh = {remy_reg[62:0], dvy_reg[62]};
    assign vx = negx_reg ? -{1'b0, qx_reg} : {1'b0, qx_reg};
    assign vy = negy_reg ? -{1'b0, qy_reg} : {1'b0, qy_reg};
    assign newx = move_axis(pos_x_reg, (len_reg == 32'd0) ? 64'd0 : vx, end_x);
    assign newy = move_axis(pos_y_reg, (len_reg == 32'd0) ? 64'd0 : vy, end_y);

    assign stat.is_load   = (item_reg.cmd == CMD_LOAD);
    assign stat.sqrt_last = (sq_cnt_reg == 6'd32);
    assign stat.div_last  = (dv_cnt_reg == 6'd62);
    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (item_reg.cmd == CMD_LOAD)
            begin
                pos_x_reg <= item_reg.load_x;
                pos_y_reg <= item_reg.load_y;
            end
            else
            begin
                pos_x_reg <= newx;
                pos_y_reg <= newy;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.prep)
        begin
            negx_reg <= dx[32];
            negy_reg <= dy[32];
            ax_reg   <= hx[31:0];
            ay_reg   <= hy[31:0];
        end
        if (cmd.sqrt_start)
        begin
            rem_reg    <= 64'(hx[31:0]) * 64'(hx[31:0]);
            res_reg    <= '0;
            bit_reg    <= 64'h4000_0000_0000_0000;
            sq_cnt_reg <= '0;
        end
        else if (cmd.sqrt_iter)
        begin
            if (sq_cnt_reg == 6'd0)
            begin
                rem_reg <= rem_reg + 64'(ay_reg) * 64'(ay_reg);
            end
            else if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            if (sq_cnt_reg == 6'd32)
            begin
                len_reg <= (rem_reg >= trial) ? 32'((res_reg >> 1) + bit_reg)
                                              : 32'(res_reg >> 1);
            end
            sq_cnt_reg <= sq_cnt_reg + 6'd1;
        end
        if (cmd.div_start)
        begin
            dvx_reg    <= 63'(item_reg.step_len) * 63'(ax_reg);
            dvy_reg    <= 63'(item_reg.step_len) * 63'(ay_reg);
            remx_reg   <= '0;
            remy_reg   <= '0;
            dv_cnt_reg <= '0;
        end
        else if (cmd.div_iter)
        begin
            dvx_reg <= dvx_reg << 1;
            dvy_reg <= dvy_reg << 1;
            if (rx_sh >= 64'(len_reg))
            begin
                remx_reg <= rx_sh - 64'(len_reg);
                qx_reg   <= {qx_reg[61:0], 1'b1};
            end
            else
            begin
                remx_reg <= rx_sh;
                qx_reg   <= {qx_reg[61:0], 1'b0};
            end
            if (ry_sh >= 64'(len_reg))
            begin
                remy_reg <= ry_sh - 64'(len_reg);
                qy_reg   <= {qy_reg[61:0], 1'b1};
            end
            else
            begin
                remy_reg <= ry_sh;
                qy_reg   <= {qy_reg[61:0], 1'b0};
            end
            dv_cnt_reg <= dv_cnt_reg + 6'd1;
        end
    end

endmodule

/* hw/rtl/pstt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstt_ctrl: transaction sequencer
// Accepts a transaction, steps the datapath through square root and
// division, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pstt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output pstt_pkg::dp_cmd_t  cmd,
    input  pstt_pkg::dp_stat_t stat
);
    import pstt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SQRT,
        S_DIV,
        S_UPDATE,
        S_OUT
    } state_t;

    state_t state_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd            = '0;
        cmd.capture    = in_valid && in_ready;
        cmd.prep       = (state_reg == S_PREP);
        cmd.sqrt_start = (state_reg == S_PREP);
        cmd.sqrt_iter  = (state_reg == S_SQRT);
        cmd.div_start  = (state_reg == S_SQRT) && stat.sqrt_last;
        cmd.div_iter   = (state_reg == S_DIV);
        cmd.update     = (state_reg == S_UPDATE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    state_reg <= stat.is_load ? S_UPDATE : S_SQRT;
                end
                S_SQRT:
                begin
                    if (stat.sqrt_last)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (stat.div_last)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/point_step_toward_target_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_step_toward_target_unit: constant-speed 2D stepping toward a target
// A step transaction passes through a setup state, a bit-serial square root
// that yields the segment length (first forming the sum of squares, then
// iterating), two parallel restoring dividers that form the velocity, an
// update state, and then presents the result and returns to idle once it is
// taken. A load transaction goes from setup straight to update and then
// presents its result.
// One transaction is in flight at a time.
// ----------------------------------------------------------------------------
module point_step_toward_target_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pstt_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pstt_pkg::out_item_t  out_data
);
    import pstt_pkg::*;

    logic [31:0] start_x_reg;
    logic [31:0] start_y_reg;
    logic [31:0] end_x_reg;
    logic [31:0] end_y_reg;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                REG_END_X:   end_x_reg   <= cfg_data;
                REG_END_Y:   end_y_reg   <= cfg_data;
                default:     end_y_reg   <= end_y_reg;
            endcase
        end
    end

    pstt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pstt_datapath u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .item    (in_data),
        .start_x (start_x_reg),
        .start_y (start_y_reg),
        .end_x   (end_x_reg),
        .end_y   (end_y_reg),
        .pos_x   (pos_x),
        .pos_y   (pos_y)
    );

    assign out_data.out_x   = pos_x;
    assign out_data.out_y   = pos_y;
    assign out_data.arrived = (pos_x == end_x_reg) && (pos_y == end_y_reg);

endmodule

/* dv/pstt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstt_checker: result predictor and comparator for the point step unit
// Watches the configuration port and both channels, computes the expected
// position and arrived flag for each accepted transaction and compares them
// in order with the results that the unit delivers.
// ----------------------------------------------------------------------------
module pstt_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  pstt_pkg::in_item_t   in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  pstt_pkg::out_item_t  out_data,
    output int                   fail_count,
    output int                   pending
);
    import pstt_pkg::*;

    logic signed [31:0] seg_sx, seg_sy, seg_ex, seg_ey;
    logic signed [31:0] pos_x, pos_y;
    out_item_t          expected_positions[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] advance_axis(input logic signed [31:0] p,
        input logic signed [63:0] v, input logic signed [31:0] e);
        logic signed [63:0] s;
        s = 64'(p) + v;
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        if (p < e)
        begin
            if (s > 64'(e))
                s = 64'(e);
        end
        else if (p > e)
        begin
            if (s < 64'(e))
                s = 64'(e);
        end
        else
            s = 64'(p);
        return s[31:0];
    endfunction

    task automatic predict_position(input in_item_t t);
        logic signed [63:0] dx, dy, vx, vy;
        logic [63:0]        ax, ay, len, qx, qy;
        out_item_t          r;
        if (t.cmd == CMD_LOAD)
        begin
            pos_x = t.load_x;
            pos_y = t.load_y;
        end
        else
        begin
            dx = 64'(seg_ex) - 64'(seg_sx);
            dy = 64'(seg_ey) - 64'(seg_sy);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
            begin
                ax = ax >> 1;
                ay = ay >> 1;
            end
            len = int_sqrt(ax * ax + ay * ay);
            vx = 0;
            vy = 0;
            if (len != 0)
            begin
                qx = (64'(t.step_len) * ax) / len;
                qy = (64'(t.step_len) * ay) / len;
                vx = dx < 0 ? -$signed(qx) : $signed(qx);
                vy = dy < 0 ? -$signed(qy) : $signed(qy);
            end
            pos_x = advance_axis(pos_x, vx, seg_ex);
            pos_y = advance_axis(pos_y, vy, seg_ey);
        end
        r.out_x = pos_x;
        r.out_y = pos_y;
        r.arrived = (pos_x == seg_ex) && (pos_y == seg_ey);
        expected_positions.push_back(r);
    endtask

    assign pending = expected_positions.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        int        errs;
        if (!rst_n)
        begin
            seg_sx <= 0;
            seg_sy <= 0;
            seg_ex <= 0;
            seg_ey <= 0;
            pos_x = 0;
            pos_y = 0;
            fail_count <= 0;
            expected_positions.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_X: seg_sx <= cfg_data;
                    REG_START_Y: seg_sy <= cfg_data;
                    REG_END_X:   seg_ex <= cfg_data;
                    REG_END_Y:   seg_ey <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_positions.size() == 0)
                begin
                    $error("unexpected result transaction");
                    errs++;
                end
                else
                begin
                    e = expected_positions.pop_front();
                    if (e.out_x !== out_data.out_x)
                    begin
                        $error("out_x expected %h actual %h", e.out_x, out_data.out_x);
                        errs++;
                    end
                    if (e.out_y !== out_data.out_y)
                    begin
                        $error("out_y expected %h actual %h", e.out_y, out_data.out_y);
                        errs++;
                    end
                    if (e.arrived !== out_data.arrived)
                    begin
                        $error("arrived expected %b actual %b", e.arrived,
                            out_data.arrived);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            if (in_valid && in_ready)
                predict_position(in_data);
        end
    end
endmodule

/* dv/point_step_toward_target_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_step_toward_target_unit_test: top of the point step unit testbench
// Programs a series of segments, sends directed and random load and step
// transactions with random idling on both sides, and reports the verdict
// from the failure count of the checker.
// ----------------------------------------------------------------------------
module point_step_toward_target_unit_test;
    import pstt_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        pending;
    bit        idle_enable;
    bit        hold_off;
    int        ready_idle_cnt;

    point_step_toward_target_unit i_dut
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    pstt_checker i_checker
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data), .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            3: return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return 32'($signed($urandom_range(0, 32'h2000000)) - 32'h1000000);
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic program_segment(input logic [31:0] sx, input logic [31:0] sy,
        input logic [31:0] ex, input logic [31:0] ey);
        stop_sending();
        repeat (120) @(posedge clk);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Y, ey);
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input logic c, input logic [31:0] lx, input logic [31:0] ly,
        input logic [30:0] sl);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_data.cmd    <= c;
        in_data.load_x <= lx;
        in_data.load_y <= ly;
        in_data.step_len <= sl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_step(input logic [30:0] sl);
        send_item(CMD_STEP, $urandom, $urandom, sl);
    endtask

    function automatic logic [30:0] pick_step();
        case ($urandom_range(0, 4))
            0: return 31'h7fff_ffff;
            1: return 31'($urandom);
            2: return 31'($urandom_range(0, 16));
            default: return 31'($urandom_range(0, 32'h40000));
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_idle_cnt <= 0;
        end
        else if (hold_off)
            out_ready <= 1'b0;
        else if (ready_idle_cnt != 0)
        begin
            out_ready <= 1'b0;
            ready_idle_cnt <= ready_idle_cnt - 1;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            ready_idle_cnt <= $urandom_range(0, 11);
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        int n;
        int k;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        idle_enable = 1'b1;
        hold_off = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero-length segment after reset, then the widest segments.
        send_item(CMD_LOAD, 32'h0001_0000, 32'hffff_0000, 31'd0);
        send_step(31'h7fff_ffff);
        program_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 31'd0);
        send_step(31'h7fff_ffff);
        send_step(31'h7fff_ffff);
        send_step(31'h7fff_ffff);
        send_step(31'd0);
        send_item(CMD_LOAD, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
        send_step(31'h0001_0000);
        program_segment(32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0);
        send_item(CMD_LOAD, 32'h7fff_0000, 32'h0000_0005, 31'd0);
        send_step(31'h4000_0000);
        send_step(31'h7fff_ffff);
        send_item(CMD_LOAD, 32'h8000_0010, 32'h0, 31'd0);
        send_step(31'h0000_0100);
        // Moving away: load past the end, on the far side of the end from the start.
        program_segment(32'h0, 32'h0, 32'h000a_0000, 32'hfff6_0000);
        send_item(CMD_LOAD, 32'h7fff_f000, 32'h8000_1000, 31'd0);
        send_step(31'h7fff_ffff);
        send_item(CMD_LOAD, 32'h0, 32'h0, 31'd0);
        send_step(31'h0003_0000);
        send_step(31'h0003_0000);
        send_step(31'h0010_0000);
        send_step(31'h1);

        for (n = 0; n < 2000; n++)
        begin
            if (n % 150 == 0)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    k = $urandom;
                    program_segment(k, k + 1, k, k + 1);
                end
                else
                    program_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            end
            if (n == 600)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (1500) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (n == 900)
                stop_sending();
            if (n == 1700)
                idle_enable = 1'b0;
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_LOAD, pick_coord(), pick_coord(), 31'($urandom));
            else
                send_step(pick_step());
        end

        stop_sending();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/pstt_pkg.sv
hw/rtl/pstt_datapath.sv
hw/rtl/pstt_ctrl.sv
hw/rtl/point_step_toward_target_unit.sv
dv/pstt_checker.sv
dv/point_step_toward_target_unit_test.sv
